// ===== rtl/swq_pkg.sv =====
// ============================================================================
// swq_pkg: shared definitions for the sliding-window quantile block
// Field widths, register indexes, reset values, controller states and the
// command and status groups between the controller and the datapath.
// ============================================================================
package swq_pkg;

  localparam int DATA_W         = 32;
  localparam int CNT_W          = 6;
  localparam int Q_W            = 17;
  localparam int FRAC_W         = 16;
  localparam int POS_W          = Q_W + CNT_W;
  localparam int PROD_W         = FRAC_W + DATA_W;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_WINDOW_DEF = 32;

  localparam logic [Q_W-1:0]    Q_ONE = 17'h10000;

  localparam logic [DATA_W-1:0] DEFAULT_VALUE_RST = 32'h0000_0000;
  localparam logic [CNT_W-1:0]  MIN_HISTORY_RST   = 6'd1;
  localparam logic [Q_W-1:0]    QUANTILE_Q_RST    = 17'h08000;
  localparam logic [CNT_W-1:0]  WINDOW_LENGTH_RST = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_VALUE = 2'd0,
    CFG_MIN_HISTORY   = 2'd1,
    CFG_QUANTILE_Q    = 2'd2,
    CFG_WINDOW_LENGTH = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVICT_CHECK,
    ST_RING_READ,
    ST_REMOVE,
    ST_STORE,
    ST_INSERT,
    ST_INSERT_LAST,
    ST_DECIDE,
    ST_READ_LO,
    ST_READ_HI,
    ST_MULTIPLY,
    ST_SUM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take_sample;
    logic ring_read;
    logic remove_step;
    logic store;
    logic insert_step;
    logic insert_last;
    logic decide;
    logic read_lo;
    logic read_hi;
    logic multiply;
    logic sum;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_evict;
    logic remove_done;
    logic held_zero;
    logic insert_done;
    logic insert_to_zero;
    logic short_history;
  } status_t;

endpackage

// ===== rtl/sliding_window_quantile_top.sv =====
// ============================================================================
// sliding_window_quantile_top: running quantile of a sliding sample window
// Samples arrive one beat at a time on the input channel (in_valid/in_ready)
// and each produces one beat on the output channel (out_valid/out_ready): the
// quantile of the most recent window_length samples by linear interpolation,
// or default_value with used_default set while fewer than min_history are held.
// Registers are written on the configuration channel, index 0 to 3; the user
// must do so only while the block is idle, which the block does not enforce.
// cfg_ready is always high. The processing time of a sample is set by the
// sorted store, which takes one read and one write a cycle and is walked once
// to remove the evicted sample and once to place the new one; each further
// eviction after window_length is lowered adds another removal walk. A new
// sample is taken only once the last result is in the output register.
// Synchronous reset empties the window and restores the register defaults.
// The result sits in an output register; a stalled receiver does not stop the
// next sample being taken and processed, but its result waits until the
// register is free.
// ============================================================================
module sliding_window_quantile_top #(
  parameter int MAX_WINDOW = swq_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swq_pkg::DATA_W-1:0]    sample_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swq_pkg::DATA_W-1:0]    quantile_value,
  output logic                                 used_default,
  output logic        [swq_pkg::CNT_W-1:0]     fill_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [swq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [swq_pkg::DATA_W-1:0]    cfg_data
);

  logic signed [swq_pkg::DATA_W-1:0] default_value;
  logic        [swq_pkg::CNT_W-1:0]  min_samples;
  logic        [swq_pkg::Q_W-1:0]    quantile_q;
  logic        [swq_pkg::CNT_W-1:0]  window_length;

  swq_pkg::cmd_t                     cmd;
  swq_pkg::status_t                  status;
  logic                              out_free;
  logic signed [swq_pkg::DATA_W-1:0] result;
  logic                              used;
  logic        [swq_pkg::CNT_W-1:0]  held;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= swq_pkg::DEFAULT_VALUE_RST;
      min_samples   <= swq_pkg::MIN_HISTORY_RST;
      quantile_q    <= swq_pkg::QUANTILE_Q_RST;
      window_length <= swq_pkg::WINDOW_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swq_pkg::CFG_DEFAULT_VALUE: default_value <= cfg_data;
        swq_pkg::CFG_MIN_HISTORY:   min_samples   <= cfg_data[swq_pkg::CNT_W-1:0];
        swq_pkg::CFG_QUANTILE_Q:    quantile_q    <= cfg_data[swq_pkg::Q_W-1:0];
        swq_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data[swq_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      quantile_value <= result;
      used_default   <= used;
      fill_count     <= held;
    end
  end

  swq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  swq_dpath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_value  (sample_value),
    .default_value (default_value),
    .min_samples   (min_samples),
    .quantile_q    (quantile_q),
    .window_length (window_length),
    .result        (result),
    .used          (used),
    .held          (held)
  );

endmodule

// ===== rtl/swq_ctrl.sv =====
// ============================================================================
// swq_ctrl: sequencer for the sliding-window quantile block
// Steps each sample through eviction, ordered insertion and interpolation,
// and hands the finished result to the output register.
// ============================================================================
module swq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_free,
  input  swq_pkg::status_t status,
  output swq_pkg::cmd_t    cmd
);

  swq_pkg::state_t state;
  swq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swq_pkg::ST_IDLE: begin
        if (in_valid) state_next = swq_pkg::ST_EVICT_CHECK;
      end
      swq_pkg::ST_EVICT_CHECK: begin
        state_next = status.need_evict ? swq_pkg::ST_RING_READ : swq_pkg::ST_STORE;
      end
      swq_pkg::ST_RING_READ: begin
        state_next = swq_pkg::ST_REMOVE;
      end
      swq_pkg::ST_REMOVE: begin
        if (status.remove_done) state_next = swq_pkg::ST_EVICT_CHECK;
      end
      swq_pkg::ST_STORE: begin
        state_next = status.held_zero ? swq_pkg::ST_DECIDE : swq_pkg::ST_INSERT;
      end
      swq_pkg::ST_INSERT: begin
        if (status.insert_done) begin
          state_next = swq_pkg::ST_DECIDE;
        end else if (status.insert_to_zero) begin
          state_next = swq_pkg::ST_INSERT_LAST;
        end
      end
      swq_pkg::ST_INSERT_LAST: begin
        state_next = swq_pkg::ST_DECIDE;
      end
      swq_pkg::ST_DECIDE: begin
        state_next = status.short_history ? swq_pkg::ST_FINISH : swq_pkg::ST_READ_LO;
      end
      swq_pkg::ST_READ_LO: begin
        state_next = swq_pkg::ST_READ_HI;
      end
      swq_pkg::ST_READ_HI: begin
        state_next = swq_pkg::ST_MULTIPLY;
      end
      swq_pkg::ST_MULTIPLY: begin
        state_next = swq_pkg::ST_SUM;
      end
      swq_pkg::ST_SUM: begin
        state_next = swq_pkg::ST_FINISH;
      end
      swq_pkg::ST_FINISH: begin
        if (out_free) state_next = swq_pkg::ST_IDLE;
      end
      default: begin
        state_next = swq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      swq_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.take_sample = in_valid;
      end
      swq_pkg::ST_RING_READ:   cmd.ring_read   = 1'b1;
      swq_pkg::ST_REMOVE:      cmd.remove_step = 1'b1;
      swq_pkg::ST_STORE:       cmd.store       = 1'b1;
      swq_pkg::ST_INSERT:      cmd.insert_step = 1'b1;
      swq_pkg::ST_INSERT_LAST: cmd.insert_last = 1'b1;
      swq_pkg::ST_DECIDE:      cmd.decide      = 1'b1;
      swq_pkg::ST_READ_LO:     cmd.read_lo     = 1'b1;
      swq_pkg::ST_READ_HI:     cmd.read_hi     = 1'b1;
      swq_pkg::ST_MULTIPLY:    cmd.multiply    = 1'b1;
      swq_pkg::ST_SUM:         cmd.sum         = 1'b1;
      swq_pkg::ST_FINISH:      cmd.finish      = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/swq_dpath.sv =====
// ============================================================================
// swq_dpath: window stores and arithmetic for the sliding-window quantile
// Holds the arrival ring and the sorted store, walks the sorted store to
// remove and insert samples, and interpolates between two sorted entries.
// ============================================================================
module swq_dpath #(
  parameter int MAX_WINDOW = swq_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  swq_pkg::cmd_t                     cmd,
  output swq_pkg::status_t                  status,
  input  logic signed [swq_pkg::DATA_W-1:0] sample_value,
  input  logic signed [swq_pkg::DATA_W-1:0] default_value,
  input  logic        [swq_pkg::CNT_W-1:0]  min_samples,
  input  logic        [swq_pkg::Q_W-1:0]    quantile_q,
  input  logic        [swq_pkg::CNT_W-1:0]  window_length,
  output logic signed [swq_pkg::DATA_W-1:0] result,
  output logic                              used,
  output logic        [swq_pkg::CNT_W-1:0]  held
);

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW   = ((AW > swq_pkg::CNT_W) ? AW : swq_pkg::CNT_W) + 1;
  localparam int WCAP = (MAX_WINDOW < 63) ? MAX_WINDOW : 63;
  localparam logic [swq_pkg::CNT_W-1:0] WIN_CAP   = swq_pkg::CNT_W'(WCAP);
  localparam logic [AW-1:0]             LAST_SLOT = AW'(MAX_WINDOW - 1);
  localparam logic [SW-1:0]             RING_SIZE = SW'(MAX_WINDOW);

  logic        [swq_pkg::DATA_W-1:0] ring_mem   [MAX_WINDOW];
  logic        [swq_pkg::DATA_W-1:0] sorted_mem [MAX_WINDOW];
  logic signed [swq_pkg::DATA_W-1:0] ring_rdata;
  logic signed [swq_pkg::DATA_W-1:0] sorted_rdata;
  logic signed [swq_pkg::DATA_W-1:0] sample;
  logic signed [swq_pkg::DATA_W-1:0] lo_value;

  logic [AW-1:0]               oldest;
  logic [swq_pkg::CNT_W-1:0]   scan_idx;
  logic [swq_pkg::CNT_W-1:0]   pend_idx;
  logic                        pend;
  logic                        found;
  logic [swq_pkg::CNT_W-1:0]   ins_idx;
  logic [swq_pkg::POS_W-1:0]   pos;
  logic [swq_pkg::PROD_W-1:0]  prod;

  logic [swq_pkg::CNT_W-1:0]   win_eff;
  logic [swq_pkg::Q_W-1:0]     q_sat;
  logic [swq_pkg::CNT_W-1:0]   held_m1;
  logic [swq_pkg::CNT_W:0]     lo_idx;
  logic [swq_pkg::CNT_W:0]     hi_idx;
  logic [swq_pkg::FRAC_W-1:0]  frac;
  logic                        greater;
  logic [SW-1:0]               ring_sum;
  logic [AW-1:0]               ring_waddr;
  logic [swq_pkg::DATA_W-1:0]  diff;

  logic                        s_re;
  logic [AW-1:0]               s_raddr;
  logic                        s_we;
  logic [AW-1:0]               s_waddr;
  logic [swq_pkg::DATA_W-1:0]  s_wdata;

  always_comb begin
    if (window_length == '0) begin
      win_eff = swq_pkg::CNT_W'(1);
    end else if (window_length > WIN_CAP) begin
      win_eff = WIN_CAP;
    end else begin
      win_eff = window_length;
    end
  end

  assign q_sat      = (quantile_q > swq_pkg::Q_ONE) ? swq_pkg::Q_ONE : quantile_q;
  assign held_m1    = held - swq_pkg::CNT_W'(1);
  assign lo_idx     = pos[swq_pkg::POS_W-1:swq_pkg::FRAC_W];
  assign frac       = pos[swq_pkg::FRAC_W-1:0];
  assign hi_idx     = lo_idx + {{swq_pkg::CNT_W{1'b0}}, (frac != '0)};
  assign greater    = sorted_rdata > sample;
  assign ring_sum   = SW'(oldest) + SW'(held);
  assign ring_waddr = (ring_sum >= RING_SIZE) ? AW'(ring_sum - RING_SIZE) : AW'(ring_sum);
  assign diff       = sorted_rdata - lo_value;

  assign status.need_evict     = held >= win_eff;
  assign status.remove_done    = pend && (scan_idx == held);
  assign status.held_zero      = held == '0;
  assign status.insert_done    = !greater;
  assign status.insert_to_zero = greater && (ins_idx == '0);
  assign status.short_history  = held < min_samples;

  always_comb begin
    s_re    = 1'b0;
    s_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = sample;
    if (cmd.remove_step) begin
      if (scan_idx < held) begin
        s_re    = 1'b1;
        s_raddr = AW'(scan_idx);
      end
      if (pend && found) begin
        s_we    = 1'b1;
        s_waddr = AW'(pend_idx - swq_pkg::CNT_W'(1));
        s_wdata = sorted_rdata;
      end
    end
    if (cmd.store) begin
      if (status.held_zero) begin
        s_we    = 1'b1;
        s_waddr = '0;
        s_wdata = sample;
      end else begin
        s_re    = 1'b1;
        s_raddr = AW'(held_m1);
      end
    end
    if (cmd.insert_step) begin
      s_we    = 1'b1;
      s_waddr = AW'(ins_idx + swq_pkg::CNT_W'(1));
      s_wdata = greater ? sorted_rdata : sample;
      if (greater && (ins_idx != '0)) begin
        s_re    = 1'b1;
        s_raddr = AW'(ins_idx - swq_pkg::CNT_W'(1));
      end
    end
    if (cmd.insert_last) begin
      s_we    = 1'b1;
      s_waddr = '0;
      s_wdata = sample;
    end
    if (cmd.read_lo) begin
      s_re    = 1'b1;
      s_raddr = AW'(lo_idx);
    end
    if (cmd.read_hi) begin
      s_re    = 1'b1;
      s_raddr = AW'(hi_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) sorted_mem[s_waddr] <= s_wdata;
    if (s_re) sorted_rdata <= sorted_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.store) ring_mem[ring_waddr] <= sample;
    if (cmd.ring_read) ring_rdata <= ring_mem[oldest];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      oldest   <= '0;
      scan_idx <= '0;
      pend_idx <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      ins_idx  <= '0;
    end else begin
      if (cmd.ring_read) begin
        scan_idx <= '0;
        pend     <= 1'b0;
        found    <= 1'b0;
      end
      if (cmd.remove_step) begin
        if (scan_idx < held) begin
          scan_idx <= scan_idx + swq_pkg::CNT_W'(1);
          pend_idx <= scan_idx;
          pend     <= 1'b1;
        end else begin
          pend     <= 1'b0;
        end
        if (pend && !found && (sorted_rdata == ring_rdata)) found <= 1'b1;
        if (status.remove_done) begin
          held   <= held_m1;
          oldest <= (oldest == LAST_SLOT) ? '0 : oldest + AW'(1);
        end
      end
      if (cmd.store) begin
        if (status.held_zero) begin
          held    <= held + swq_pkg::CNT_W'(1);
        end else begin
          ins_idx <= held_m1;
        end
      end
      if (cmd.insert_step) begin
        if (greater && (ins_idx != '0)) ins_idx <= ins_idx - swq_pkg::CNT_W'(1);
        if (!greater) held <= held + swq_pkg::CNT_W'(1);
      end
      if (cmd.insert_last) held <= held + swq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) sample <= sample_value;
    if (cmd.decide) begin
      if (status.short_history) begin
        result <= default_value;
        used   <= 1'b1;
      end else begin
        pos <= swq_pkg::POS_W'(q_sat) * swq_pkg::POS_W'(held_m1);
      end
    end
    if (cmd.read_hi) lo_value <= sorted_rdata;
    if (cmd.multiply) prod <= swq_pkg::PROD_W'(frac) * swq_pkg::PROD_W'(diff);
    if (cmd.sum) begin
      result <= lo_value + prod[swq_pkg::PROD_W-1:swq_pkg::FRAC_W];
      used   <= 1'b0;
    end
  end

  a_held_cap: assert property (@(posedge clk) disable iff (rst)
    held <= WIN_CAP)
    else $error("Window holds more samples than it can.");

  a_oldest_range: assert property (@(posedge clk) disable iff (rst)
    oldest <= LAST_SLOT)
    else $error("Oldest pointer outside the ring.");

  a_remove_found: assert property (@(posedge clk) disable iff (rst)
    cmd.remove_step && status.remove_done |-> found || (sorted_rdata == ring_rdata))
    else $error("Evicted sample missing from the sorted store.");

  a_insert_index: assert property (@(posedge clk) disable iff (rst)
    cmd.insert_step |-> ins_idx < held)
    else $error("Insertion walk outside the held samples.");

endmodule
